FILE: rtl/v3alu_pkg.sv
`default_nettype none

package v3alu_pkg;

	localparam int DEF_FRAC_BITS = 16;

	localparam logic [3:0] CMD_ADD    = 4'd0;
	localparam logic [3:0] CMD_SUB    = 4'd1;
	localparam logic [3:0] CMD_MUL    = 4'd2;
	localparam logic [3:0] CMD_SCALE  = 4'd3;
	localparam logic [3:0] CMD_DIV    = 4'd4;
	localparam logic [3:0] CMD_DIVSC  = 4'd5;
	localparam logic [3:0] CMD_DOT    = 4'd6;
	localparam logic [3:0] CMD_CROSS  = 4'd7;
	localparam logic [3:0] CMD_LENGTH = 4'd8;
	localparam logic [3:0] CMD_NORM   = 4'd9;
	localparam logic [3:0] CMD_EQUAL  = 4'd10;

	localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] S32_MIN = 32'h8000_0000;

	typedef struct packed {
		logic [3:0]         command;
		logic signed [31:0] ax;
		logic signed [31:0] ay;
		logic signed [31:0] az;
		logic signed [31:0] bx;
		logic signed [31:0] by;
		logic signed [31:0] bz;
		logic signed [31:0] scalar_in;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] rx;
		logic signed [31:0] ry;
		logic signed [31:0] rz;
		logic signed [31:0] scalar_out;
		logic               is_equal;
		logic               div_by_zero;
		logic               overflow;
	} out_item_t;

	typedef struct packed {
		logic [3:0]       cmd;
		logic [2:0][31:0] a;
		logic [2:0][31:0] b;
		logic [31:0]      s;
		logic             eq;
	} base_t;

	typedef struct packed {
		logic [3:0]       cmd;
		logic [2:0][31:0] a;
		logic [2:0][31:0] b;
		logic [31:0]      s;
		logic [2:0][31:0] r;
		logic [31:0]      sc;
		logic             eq;
		logic             ovf;
	} carry_t;

	typedef struct packed {
		logic [2:0][31:0] r;
		logic [31:0]      sc;
		logic             eq;
		logic             ovf;
		logic             isdiv;
		logic [2:0]       neg;
		logic [2:0]       apos;
		logic [2:0]       aneg;
	} dcarry_t;

endpackage

`default_nettype wire

FILE: rtl/vector3_alu_fixed.sv
`default_nettype none

// Three-component vector unit in signed fixed point with FRAC_BITS fraction
// bits: add, sub, per-component mul and div, scale, divide by scalar, dot,
// cross, length, normalize and equality. One item is accepted per cycle
// unless the output register holds a result that is not taken. Every item
// passes through three stages of multiply and sum, a 32-stage square root,
// and a restoring divider of 32 + FRAC_BITS stages, one quotient bit per
// stage, in which every command travels. The pipeline advances as a whole
// and holds while the output register keeps a result that is not taken.
module vector3_alu_fixed #(
	parameter int FRAC_BITS = v3alu_pkg::DEF_FRAC_BITS
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_ready,
	input  wire v3alu_pkg::in_item_t in_item,
	output logic                  out_valid,
	input  wire                   out_ready,
	output v3alu_pkg::out_item_t  out_item
);

	localparam int SQ_STEPS = 32;
	localparam int NB = 32 + FRAC_BITS;
	localparam logic [NB-1:0] Q_POS_MAX = NB'(33'h0_7FFF_FFFF);
	localparam logic [NB-1:0] Q_NEG_MAX = NB'(33'h0_8000_0000);

	function automatic logic [32:0] sat66(input logic signed [65:0] v);
		if (v > 66'sd2147483647)
			sat66 = {1'b1, v3alu_pkg::S32_MAX};
		else if (v < -66'sd2147483648)
			sat66 = {1'b1, v3alu_pkg::S32_MIN};
		else
			sat66 = {1'b0, v[31:0]};
	endfunction

	logic en;

	// stage 1
	logic                  vld_s1;
	v3alu_pkg::base_t      base_s1;
	// stage 2
	logic                  vld_s2;
	v3alu_pkg::base_t      base_s2;
	logic signed [63:0]    prod_s2 [0:5];
	// stage 3
	logic                  vld_s3;
	v3alu_pkg::base_t      base_s3;
	logic signed [65:0]    v_s3 [0:2];
	logic [63:0]           sumsq_s3;
	// square root stages
	logic                  vld_sq [0:SQ_STEPS];
	logic [63:0]           n_sq [0:SQ_STEPS];
	logic [63:0]           r_sq [0:SQ_STEPS];
	v3alu_pkg::carry_t     cr_sq [0:SQ_STEPS];
	// divider stages
	logic                  vld_dv [0:NB];
	logic [31:0]           rem_dv [0:NB][0:2];
	logic [NB-1:0]         nq_dv [0:NB][0:2];
	logic [31:0]           d_dv [0:NB][0:2];
	v3alu_pkg::dcarry_t    dc_dv [0:NB];
	// output
	logic                  vld_so;
	v3alu_pkg::out_item_t  res_so;

	assign en = !vld_so || out_ready;
	assign in_ready = en;
	assign out_valid = vld_so;
	assign out_item = res_so;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			for (int k = 0; k <= SQ_STEPS; k++) vld_sq[k] <= 1'b0;
			for (int k = 0; k <= NB; k++) vld_dv[k] <= 1'b0;
			vld_so <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_sq[0] <= vld_s3;
			for (int k = 1; k <= SQ_STEPS; k++) vld_sq[k] <= vld_sq[k-1];
			vld_dv[0] <= vld_sq[SQ_STEPS];
			for (int k = 1; k <= NB; k++) vld_dv[k] <= vld_dv[k-1];
			vld_so <= vld_dv[NB];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			base_s1.cmd  <= in_item.command;
			base_s1.a[0] <= in_item.ax;
			base_s1.a[1] <= in_item.ay;
			base_s1.a[2] <= in_item.az;
			base_s1.b[0] <= in_item.bx;
			base_s1.b[1] <= in_item.by;
			base_s1.b[2] <= in_item.bz;
			base_s1.s    <= in_item.scalar_in;
			base_s1.eq   <= (in_item.command == v3alu_pkg::CMD_EQUAL) &&
				(in_item.ax == in_item.bx) && (in_item.ay == in_item.by) &&
				(in_item.az == in_item.bz);
		end
	end

	// multiply operand select
	logic signed [31:0] ma [0:5];
	logic signed [31:0] mb [0:5];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ma[i] = $signed(base_s1.a[i]);
			mb[i] = $signed(base_s1.b[i]);
		end
		case (base_s1.cmd)
			v3alu_pkg::CMD_SCALE: begin
				for (int i = 0; i < 3; i++) mb[i] = $signed(base_s1.s);
			end
			v3alu_pkg::CMD_LENGTH, v3alu_pkg::CMD_NORM: begin
				for (int i = 0; i < 3; i++) mb[i] = $signed(base_s1.a[i]);
			end
			v3alu_pkg::CMD_CROSS: begin
				ma[0] = $signed(base_s1.a[1]); mb[0] = $signed(base_s1.b[2]);
				ma[1] = $signed(base_s1.a[2]); mb[1] = $signed(base_s1.b[1]);
				ma[2] = $signed(base_s1.a[2]); mb[2] = $signed(base_s1.b[0]);
			end
			default: begin
			end
		endcase
		ma[3] = $signed(base_s1.a[0]); mb[3] = $signed(base_s1.b[2]);
		ma[4] = $signed(base_s1.a[0]); mb[4] = $signed(base_s1.b[1]);
		ma[5] = $signed(base_s1.a[1]); mb[5] = $signed(base_s1.b[0]);
	end

	logic signed [63:0] prod [0:5];

	always_comb begin
		for (int k = 0; k < 6; k++)
			prod[k] = {{32{ma[k][31]}}, ma[k]} * {{32{mb[k][31]}}, mb[k]};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 6; k++) prod_s2[k] <= prod[k];
			base_s2 <= base_s1;
		end
	end

	// truncate products and combine
	logic signed [63:0] t [0:5];
	logic signed [65:0] tx [0:5];
	logic signed [65:0] ax66 [0:2];
	logic signed [65:0] bx66 [0:2];
	logic signed [65:0] v [0:2];
	logic [63:0]        sumsq;

	always_comb begin
		for (int k = 0; k < 6; k++) begin
			t[k] = prod_s2[k] >>> FRAC_BITS;
			tx[k] = {{2{t[k][63]}}, t[k]};
		end
		for (int i = 0; i < 3; i++) begin
			ax66[i] = {{34{base_s2.a[i][31]}}, base_s2.a[i]};
			bx66[i] = {{34{base_s2.b[i][31]}}, base_s2.b[i]};
			v[i] = '0;
		end
		case (base_s2.cmd)
			v3alu_pkg::CMD_ADD: begin
				for (int i = 0; i < 3; i++) v[i] = ax66[i] + bx66[i];
			end
			v3alu_pkg::CMD_SUB: begin
				for (int i = 0; i < 3; i++) v[i] = ax66[i] - bx66[i];
			end
			v3alu_pkg::CMD_MUL, v3alu_pkg::CMD_SCALE: begin
				for (int i = 0; i < 3; i++) v[i] = tx[i];
			end
			v3alu_pkg::CMD_DOT: begin
				v[0] = tx[0] + tx[1] + tx[2];
			end
			v3alu_pkg::CMD_CROSS: begin
				v[0] = tx[0] - tx[1];
				v[1] = tx[2] - tx[3];
				v[2] = tx[4] - tx[5];
			end
			default: begin
			end
		endcase
		sumsq = $unsigned(prod_s2[0]) + $unsigned(prod_s2[1]) + $unsigned(prod_s2[2]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) v_s3[i] <= v[i];
			sumsq_s3 <= sumsq;
			base_s3 <= base_s2;
		end
	end

	// saturate and start the root
	logic [32:0]       sv [0:2];
	v3alu_pkg::carry_t cr0;

	always_comb begin
		for (int i = 0; i < 3; i++) sv[i] = sat66(v_s3[i]);
		cr0.cmd = base_s3.cmd;
		cr0.a   = base_s3.a;
		cr0.b   = base_s3.b;
		cr0.s   = base_s3.s;
		cr0.eq  = base_s3.eq;
		cr0.r   = '0;
		cr0.sc  = '0;
		cr0.ovf = 1'b0;
		case (base_s3.cmd)
			v3alu_pkg::CMD_ADD, v3alu_pkg::CMD_SUB, v3alu_pkg::CMD_MUL,
			v3alu_pkg::CMD_SCALE, v3alu_pkg::CMD_CROSS: begin
				for (int i = 0; i < 3; i++) cr0.r[i] = sv[i][31:0];
				cr0.ovf = sv[0][32] | sv[1][32] | sv[2][32];
			end
			v3alu_pkg::CMD_DOT: begin
				cr0.sc  = sv[0][31:0];
				cr0.ovf = sv[0][32];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_sq[0]  <= sumsq_s3;
			r_sq[0]  <= '0;
			cr_sq[0] <= cr0;
		end
	end

	for (genvar k = 1; k <= SQ_STEPS; k++) begin : g_sq
		localparam int SH = 62 - 2 * (k - 1);
		logic [63:0] bitv;
		logic [63:0] trial;
		logic        ge;

		assign bitv  = 64'd1 << SH;
		assign trial = r_sq[k-1] + bitv;
		assign ge    = n_sq[k-1] >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				n_sq[k]  <= ge ? n_sq[k-1] - trial : n_sq[k-1];
				r_sq[k]  <= ge ? (r_sq[k-1] >> 1) + bitv : r_sq[k-1] >> 1;
				cr_sq[k] <= cr_sq[k-1];
			end
		end
	end

	// divider setup
	logic [31:0]        len;
	v3alu_pkg::carry_t  crl;
	v3alu_pkg::dcarry_t dc0;
	logic [31:0]        dsel [0:2];
	logic [31:0]        dmag [0:2];
	logic [31:0]        amag [0:2];
	logic [2:0]         dneg;

	assign len = r_sq[SQ_STEPS][31:0];
	assign crl = cr_sq[SQ_STEPS];

	always_comb begin
		dc0.r     = crl.r;
		dc0.sc    = crl.sc;
		dc0.eq    = crl.eq;
		dc0.ovf   = crl.ovf;
		dc0.isdiv = (crl.cmd == v3alu_pkg::CMD_DIV) || (crl.cmd == v3alu_pkg::CMD_DIVSC) ||
			(crl.cmd == v3alu_pkg::CMD_NORM);
		if (crl.cmd == v3alu_pkg::CMD_LENGTH) begin
			dc0.sc  = len[31] ? v3alu_pkg::S32_MAX : len;
			dc0.ovf = len[31];
		end
		for (int i = 0; i < 3; i++) begin
			dsel[i] = (crl.cmd == v3alu_pkg::CMD_DIV) ? crl.b[i] : crl.s;
			if (crl.cmd == v3alu_pkg::CMD_NORM) begin
				dneg[i] = 1'b0;
				dmag[i] = len;
			end else begin
				dneg[i] = dsel[i][31];
				dmag[i] = dsel[i][31] ? (~dsel[i] + 32'd1) : dsel[i];
			end
			amag[i]     = crl.a[i][31] ? (~crl.a[i] + 32'd1) : crl.a[i];
			dc0.neg[i]  = crl.a[i][31] ^ dneg[i];
			dc0.aneg[i] = crl.a[i][31];
			dc0.apos[i] = !crl.a[i][31] && (crl.a[i] != 32'd0);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				rem_dv[0][i] <= '0;
				nq_dv[0][i]  <= {amag[i], {FRAC_BITS{1'b0}}};
				d_dv[0][i]   <= dmag[i];
			end
			dc_dv[0] <= dc0;
		end
	end

	for (genvar k = 1; k <= NB; k++) begin : g_dv
		for (genvar i = 0; i < 3; i++) begin : g_lane
			logic [32:0] rsh;
			logic        ge;

			assign rsh = {rem_dv[k-1][i], nq_dv[k-1][i][NB-1]};
			assign ge  = rsh >= {1'b0, d_dv[k-1][i]};

			always_ff @(posedge clk) begin
				if (en) begin
					rem_dv[k][i] <= ge ? 32'(rsh - {1'b0, d_dv[k-1][i]}) : rsh[31:0];
					nq_dv[k][i]  <= {nq_dv[k-1][i][NB-2:0], ge};
					d_dv[k][i]   <= d_dv[k-1][i];
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) dc_dv[k] <= dc_dv[k-1];
		end
	end

	// finish quotients
	v3alu_pkg::dcarry_t   dcl;
	v3alu_pkg::out_item_t res;
	logic [31:0]          qr [0:2];
	logic [2:0]           qovf;
	logic [2:0]           qdz;
	logic [NB-1:0]        q [0:2];

	assign dcl = dc_dv[NB];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			q[i] = nq_dv[NB][i];
			qovf[i] = 1'b0;
			qdz[i] = 1'b0;
			if (d_dv[NB][i] == 32'd0) begin
				qdz[i] = 1'b1;
				qr[i] = dcl.apos[i] ? v3alu_pkg::S32_MAX :
					(dcl.aneg[i] ? v3alu_pkg::S32_MIN : 32'd0);
			end else if (dcl.neg[i]) begin
				if (q[i] > Q_NEG_MAX) begin
					qovf[i] = 1'b1;
					qr[i] = v3alu_pkg::S32_MIN;
				end else begin
					qr[i] = ~q[i][31:0] + 32'd1;
				end
			end else begin
				if (q[i] > Q_POS_MAX) begin
					qovf[i] = 1'b1;
					qr[i] = v3alu_pkg::S32_MAX;
				end else begin
					qr[i] = q[i][31:0];
				end
			end
		end
		res.scalar_out = dcl.sc;
		res.is_equal   = dcl.eq;
		if (dcl.isdiv) begin
			res.rx          = qr[0];
			res.ry          = qr[1];
			res.rz          = qr[2];
			res.div_by_zero = |qdz;
			res.overflow    = dcl.ovf | (|qovf);
		end else begin
			res.rx          = dcl.r[0];
			res.ry          = dcl.r[1];
			res.rz          = dcl.r[2];
			res.div_by_zero = 1'b0;
			res.overflow    = dcl.ovf;
		end
	end

	always_ff @(posedge clk) begin
		if (en) res_so <= res;
	end

endmodule

`default_nettype wire
